/* design/assert_macros.svh */
// assertion helpers included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define BAMDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define BAMDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/bamde_pkg.sv */
package bamde_pkg;

    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT     = 2'd2;

    localparam logic [ADDR_W-1:0] FILTER_ADDRESS_RST = 48'hC098_E54E_0397;
    localparam logic [BYTE_W-1:0] WANTED_TYPE_RST    = 8'hFF;
    localparam logic [BYTE_W-1:0] SKIP_COUNT_RST     = 8'd2;
    localparam logic [BYTE_W-1:0] DATA_INDEX_MAX     = 8'hFF;

    typedef enum logic [2:0] {
        PH_LEN  = 3'b001,
        PH_TYPE = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] message_byte;
        logic              message_last;
    } msg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* design/bamde_if.sv */
interface bamde_report_if;
    logic                            valid;
    logic                            ready;
    logic [bamde_pkg::BYTE_W-1:0]    report_byte;
    logic                            report_first;
    logic                            report_end;
    logic [bamde_pkg::ADDR_W-1:0]    peer_address;

    modport source (output valid, output report_byte, output report_first,
                    output report_end, output peer_address, input ready);
    modport sink   (input valid, input report_byte, input report_first,
                    input report_end, input peer_address, output ready);
endinterface

interface bamde_message_if;
    logic                            valid;
    logic                            ready;
    logic [bamde_pkg::BYTE_W-1:0]    message_byte;
    logic                            message_last;

    modport source (output valid, output message_byte, output message_last, input ready);
    modport sink   (input valid, input message_byte, input message_last, output ready);
endinterface

interface bamde_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bamde_pkg::CFG_IDX_W-1:0]   index;
    logic [bamde_pkg::ADDR_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/bamde_front.sv */
module bamde_front (
    input  logic                  clk,
    input  logic                  rst_n,
    bamde_report_if.sink          report,
    bamde_cfg_if.sink             cfg,
    input  bamde_pkg::q_status_t  q_status,
    output logic                  push,
    output bamde_pkg::msg_t       push_msg
);

    logic [bamde_pkg::ADDR_W-1:0] filter_address_reg;
    logic [bamde_pkg::BYTE_W-1:0] wanted_type_reg;
    logic [bamde_pkg::BYTE_W-1:0] skip_count_reg;

    logic                         matched_reg, matched_next;
    bamde_pkg::phase_t            phase_reg, phase_next;
    logic [bamde_pkg::BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [bamde_pkg::BYTE_W-1:0] cur_type_reg, cur_type_next;
    logic [bamde_pkg::BYTE_W-1:0] data_index_reg, data_index_next;

    logic accept;
    logic emit;
    logic last;

    assign report.ready = !q_status.full;
    assign cfg.ready    = 1'b1;
    assign accept       = report.valid && report.ready;

    always_comb
    begin
        matched_next    = matched_reg;
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        cur_type_next   = cur_type_reg;
        data_index_next = data_index_reg;
        emit            = 1'b0;
        last            = 1'b0;

        // a new report restarts the walk
        if (report.report_first)
        begin
            matched_next    = (report.peer_address == filter_address_reg);
            phase_next      = bamde_pkg::PH_LEN;
            bytes_left_next = '0;
            cur_type_next   = '0;
            data_index_next = '0;
        end

        if (matched_next)
        begin
            case (phase_next)
                bamde_pkg::PH_TYPE:
                begin
                    cur_type_next   = report.report_byte;
                    bytes_left_next = bytes_left_next - 8'd1;
                    data_index_next = '0;
                    phase_next      = (bytes_left_next == '0) ? bamde_pkg::PH_LEN
                                                               : bamde_pkg::PH_DATA;
                end
                bamde_pkg::PH_DATA:
                begin
                    bytes_left_next = bytes_left_next - 8'd1;
                    if ((cur_type_next == wanted_type_reg)
                        && (data_index_next >= skip_count_reg))
                    begin
                        emit = 1'b1;
                        last = (bytes_left_next == '0) || report.report_end;
                    end
                    if (data_index_next != bamde_pkg::DATA_INDEX_MAX)
                    begin
                        data_index_next = data_index_next + 8'd1;
                    end
                    if (bytes_left_next == '0)
                    begin
                        phase_next = bamde_pkg::PH_LEN;
                    end
                end
                default:
                begin
                    bytes_left_next = report.report_byte;
                    phase_next      = (report.report_byte == '0) ? bamde_pkg::PH_LEN
                                                                  : bamde_pkg::PH_TYPE;
                end
            endcase
        end

        // structures running past the report end are cut off
        if (report.report_end)
        begin
            matched_next    = 1'b0;
            phase_next      = bamde_pkg::PH_LEN;
            bytes_left_next = '0;
        end
    end

    assign push                  = accept && emit;
    assign push_msg.message_byte = report.report_byte;
    assign push_msg.message_last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_address_reg <= bamde_pkg::FILTER_ADDRESS_RST;
            wanted_type_reg    <= bamde_pkg::WANTED_TYPE_RST;
            skip_count_reg     <= bamde_pkg::SKIP_COUNT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                bamde_pkg::CFG_FILTER_ADDRESS: filter_address_reg <= cfg.data;
                bamde_pkg::CFG_WANTED_TYPE:    wanted_type_reg <= cfg.data[7:0];
                bamde_pkg::CFG_SKIP_COUNT:     skip_count_reg <= cfg.data[7:0];
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg    <= 1'b0;
            phase_reg      <= bamde_pkg::PH_LEN;
            bytes_left_reg <= '0;
            cur_type_reg   <= '0;
            data_index_reg <= '0;
        end
        else if (accept)
        begin
            matched_reg    <= matched_next;
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            cur_type_reg   <= cur_type_next;
            data_index_reg <= data_index_next;
        end
    end

endmodule

/* design/bamde_queue.sv */
`include "assert_macros.svh"

module bamde_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bamde_pkg::msg_t       push_msg,
    input  logic                  pop,
    output bamde_pkg::msg_t       head_msg,
    output bamde_pkg::q_status_t  q_status
);

    bamde_pkg::msg_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_msg       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_msg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    `BAMDE_ASSERT_ALWAYS(a_count_bound, clk, !rst_n || (count_reg != 2'd3), "queue count out of range")
    `BAMDE_ASSERT(a_no_drop, clk, rst_n, push |-> !q_status.full, "request pushed into full queue")
    `BAMDE_ASSERT(a_fill, clk, rst_n, (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1), "queue count did not rise")
    `BAMDE_ASSERT(a_ptr_gap, clk, rst_n, (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers out of step")

endmodule

/* design/bamde_back.sv */
module bamde_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bamde_pkg::q_status_t  q_status,
    input  bamde_pkg::msg_t       head_msg,
    output logic                  pop,
    bamde_message_if.source       message
);

    logic            out_valid_reg;
    bamde_pkg::msg_t out_msg_reg;

    // refill the output register whenever it is empty or being taken
    assign pop = !q_status.empty && (!out_valid_reg || message.ready);

    assign message.valid        = out_valid_reg;
    assign message.message_byte = out_msg_reg.message_byte;
    assign message.message_last = out_msg_reg.message_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (message.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_msg_reg <= head_msg;
        end
    end

endmodule

/* design/ble_adv_manufacturer_data_extract_core.sv */
// extracts manufacturer data bytes from advertisement reports
// report channel: one payload byte per request; report_first marks the first
//   byte and carries peer_address, report_end marks the last byte
// message channel: one request per extracted data byte, message_last set on
//   the final byte of a structure or on a byte cut off by the report end
// cfg channel: index 0 filter_address, 1 wanted_type, 2 skip_count; always
//   ready, write only while no report bytes are in flight
// throughput: one report byte per cycle while the queue is not full, the parser
//   state updates in the cycle the byte is accepted
// an extracted byte enters the queue on the edge its report byte is accepted,
//   then moves from the queue into the output register, from which the
//   receiver takes it off the message channel
// stall: the queue plus output register hold three messages; once both queue
//   entries are taken report.ready drops until the receiver takes one
// reset: rst_n clears the parser to expect a length byte outside any report,
//   empties the queue and loads the default configuration
module ble_adv_manufacturer_data_extract_core (
    input  logic             clk,
    input  logic             rst_n,
    bamde_report_if.sink     report,
    bamde_message_if.source  message,
    bamde_cfg_if.sink        cfg
);

    logic                 push;
    logic                 pop;
    bamde_pkg::msg_t      push_msg;
    bamde_pkg::msg_t      head_msg;
    bamde_pkg::q_status_t q_status;

    bamde_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .report   (report),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .push_msg (push_msg)
    );

    bamde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_msg (push_msg),
        .pop      (pop),
        .head_msg (head_msg),
        .q_status (q_status)
    );

    bamde_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head_msg (head_msg),
        .pop      (pop),
        .message  (message)
    );

endmodule

/* bench/ble_adv_manufacturer_data_extract_core_test.sv */
module ble_adv_manufacturer_data_extract_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE_CYCS = 8;
    localparam int MAX_GAP     = 17;

    typedef logic [bamde_pkg::BYTE_W-1:0] byte_t;
    typedef logic [bamde_pkg::ADDR_W-1:0] addr_t;
    typedef logic [bamde_pkg::CFG_IDX_W-1:0] idx_t;

    class extract_tracker;
        addr_t             filter_addr;
        byte_t             wanted;
        byte_t             skip;
        logic              matched;
        bamde_pkg::phase_t stage;
        byte_t             left;
        byte_t             ctype;
        byte_t             dindex;
        bamde_pkg::msg_t   expected_msgs[$];
        int                mismatches;
        int                checked;

        function new();
            filter_addr = bamde_pkg::FILTER_ADDRESS_RST;
            wanted      = bamde_pkg::WANTED_TYPE_RST;
            skip        = bamde_pkg::SKIP_COUNT_RST;
            matched     = 1'b0;
            stage       = bamde_pkg::PH_LEN;
            left        = '0;
            ctype       = '0;
            dindex      = '0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void set_reg(idx_t idx, addr_t val);
            case (idx)
                bamde_pkg::CFG_FILTER_ADDRESS: filter_addr = val;
                bamde_pkg::CFG_WANTED_TYPE:    wanted = val[bamde_pkg::BYTE_W-1:0];
                bamde_pkg::CFG_SKIP_COUNT:     skip = val[bamde_pkg::BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_report_byte(byte_t b, logic first, logic closes, addr_t addr);
            bamde_pkg::msg_t m;
            if (first)
            begin
                matched = (addr == filter_addr);
                stage   = bamde_pkg::PH_LEN;
                left    = '0;
                ctype   = '0;
                dindex  = '0;
            end
            if (matched)
            begin
                case (stage)
                    bamde_pkg::PH_TYPE:
                    begin
                        ctype  = b;
                        left   = left - 1'b1;
                        dindex = '0;
                        stage  = (left == 0) ? bamde_pkg::PH_LEN : bamde_pkg::PH_DATA;
                    end
                    bamde_pkg::PH_DATA:
                    begin
                        left = left - 1'b1;
                        if (ctype == wanted && dindex >= skip)
                        begin
                            m.message_byte = b;
                            m.message_last = (left == 0) || closes;
                            expected_msgs.push_back(m);
                        end
                        if (dindex != bamde_pkg::DATA_INDEX_MAX)
                            dindex = dindex + 1'b1;
                        if (left == 0)
                            stage = bamde_pkg::PH_LEN;
                    end
                    default:
                    begin
                        left  = b;
                        stage = (b == 0) ? bamde_pkg::PH_LEN : bamde_pkg::PH_TYPE;
                    end
                endcase
            end
            // report end drops out of the report whatever the structure state
            if (closes)
            begin
                matched = 1'b0;
                stage   = bamde_pkg::PH_LEN;
                left    = '0;
            end
        endfunction

        function void check_message(byte_t b, logic last_flag);
            bamde_pkg::msg_t m;
            if (expected_msgs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected message byte %02h last %0b", b, last_flag);
                return;
            end
            m = expected_msgs.pop_front();
            checked++;
            if (m.message_byte !== b || m.message_last !== last_flag)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("message %0d: expected byte %02h last %0b, got byte %02h last %0b",
                             checked, m.message_byte, m.message_last, b, last_flag);
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bamde_report_if  rpt();
    bamde_message_if msg();
    bamde_cfg_if     cfg();

    ble_adv_manufacturer_data_extract_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .report  (rpt),
        .message (msg),
        .cfg     (cfg)
    );

    always #1 clk = ~clk;

    extract_tracker tracker = new();

    byte_t             frame[$];
    addr_t             filter_mirror = bamde_pkg::FILTER_ADDRESS_RST;
    byte_t             type_mirror   = bamde_pkg::WANTED_TYPE_RST;
    byte_t             skip_mirror   = bamde_pkg::SKIP_COUNT_RST;
    bit                tx_steady;
    bit                rx_steady;
    int                sent_items;
    int                settings_run;
    int                cut_reports;
    int                idle_cycles;

    function automatic addr_t rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[bamde_pkg::ADDR_W-1:0];
    endfunction

    // request and write acceptance, message checking, stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            bit moved;
            moved = 1'b0;
            if (rpt.valid === 1'b1 && rpt.ready === 1'b1)
            begin
                tracker.take_report_byte(rpt.report_byte, rpt.report_first,
                                         rpt.report_end, rpt.peer_address);
                moved = 1'b1;
            end
            if (msg.valid === 1'b1 && msg.ready === 1'b1)
            begin
                tracker.check_message(msg.message_byte, msg.message_last);
                moved = 1'b1;
            end
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                tracker.set_reg(cfg.index, cfg.data);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // message receiver with random stalls
    initial
    begin
        int gap;
        msg.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                @(negedge clk);
                msg.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            msg.ready <= 1'b1;
            do @(posedge clk); while (!(msg.valid === 1'b1 && msg.ready === 1'b1));
        end
    end

    task automatic send_item(input byte_t b, input logic first,
                             input logic closes, input addr_t addr);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            rpt.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rpt.valid        <= 1'b1;
        rpt.report_byte  <= b;
        rpt.report_first <= first;
        rpt.report_end   <= closes;
        // address is only looked at on the first byte
        rpt.peer_address <= first ? addr : rand_addr();
        do @(posedge clk); while (!(rpt.valid === 1'b1 && rpt.ready === 1'b1));
        sent_items++;
    endtask

    task automatic send_frame(input addr_t addr, input bit with_end);
        for (int i = 0; i < frame.size(); i++)
            send_item(frame[i], i == 0, with_end && (i == frame.size() - 1), addr);
    endtask

    task automatic write_reg(input idx_t idx, input addr_t val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!(cfg.valid === 1'b1 && cfg.ready === 1'b1));
        @(negedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            bamde_pkg::CFG_FILTER_ADDRESS: filter_mirror = val;
            bamde_pkg::CFG_WANTED_TYPE:    type_mirror = val[bamde_pkg::BYTE_W-1:0];
            bamde_pkg::CFG_SKIP_COUNT:     skip_mirror = val[bamde_pkg::BYTE_W-1:0];
            default: ;
        endcase
    endtask

    // hold off requests until every extracted byte has come out
    task automatic drain();
        @(negedge clk);
        rpt.valid <= 1'b0;
        while (tracker.expected_msgs.size() != 0)
            @(posedge clk);
    endtask

    // close any open report and let the pipeline empty before a register write
    task automatic settle();
        send_item(byte_t'($urandom), 1'b1, 1'b1, rand_addr());
        drain();
        repeat (SETTLE_CYCS) @(posedge clk);
    endtask

    function automatic void build_report();
        int nstruct;
        int len;
        int sel;
        int hi;
        byte_t stype;
        frame.delete();
        nstruct = $urandom_range(1, 4);
        for (int s = 0; s < nstruct; s++)
        begin
            stype = ($urandom_range(0, 9) < 7) ? type_mirror : byte_t'($urandom);
            sel = $urandom_range(0, 9);
            hi  = int'(skip_mirror) + 6;
            if (hi > 255)
                hi = 255;
            if (sel == 0)
                len = 0;
            else if (sel < 8)
                len = $urandom_range(1, hi);
            else
                len = $urandom_range(1, 40);
            frame.push_back(byte_t'(len));
            if (len > 0)
                frame.push_back(stype);
            for (int d = 1; d < len; d++)
                frame.push_back(byte_t'($urandom));
        end
        // overrun: chop the report somewhere inside
        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(1, frame.size());
            while (frame.size() > len)
                void'(frame.pop_back());
            cut_reports++;
        end
    endfunction

    task automatic run_random(input int budget);
        int target;
        int r;
        int n;
        addr_t addr;
        target = sent_items + budget;
        while (sent_items < target)
        begin
            if ($urandom_range(0, 9) == 0)
                tx_steady = !tx_steady;
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                build_report();
                send_frame(filter_mirror, $urandom_range(0, 9) != 0);
            end
            else if (r < 88)
            begin
                build_report();
                if ($urandom_range(0, 1) == 0)
                    addr = filter_mirror ^ (48'h1 << $urandom_range(0, bamde_pkg::ADDR_W - 1));
                else
                    addr = rand_addr();
                send_frame(addr, 1'b1);
            end
            else if (r < 96)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(byte_t'($urandom), 1'b0, 1'b0, rand_addr());
            end
            else
                drain();
        end
    endtask

    initial
    begin
        rpt.valid        = 1'b0;
        rpt.report_byte  = '0;
        rpt.report_first = 1'b0;
        rpt.report_end   = 1'b0;
        rpt.peer_address = '0;
        cfg.valid        = 1'b0;
        cfg.index        = bamde_pkg::CFG_FILTER_ADDRESS;
        cfg.data         = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero length, emitted data, other type, too short, cut off at report end
        frame = '{8'h00, 8'h06, 8'hFF, 8'h59, 8'h00, 8'h00, 8'hFF, 8'h80,
                  8'h02, 8'h09, 8'h41, 8'h03, 8'hFF, 8'h4C, 8'h00,
                  8'h05, 8'hFF, 8'h01, 8'h02, 8'h03};
        send_frame(bamde_pkg::FILTER_ADDRESS_RST, 1'b1);
        // address off by one bit
        frame = '{8'h02, 8'hFF, 8'h77};
        send_frame(bamde_pkg::FILTER_ADDRESS_RST ^ 48'h1, 1'b1);
        // stray byte outside a report
        send_item(8'hFF, 1'b0, 1'b0, '1);
        // one-byte reports at the address extremes
        send_item(8'h00, 1'b1, 1'b1, '0);
        send_item(8'hFF, 1'b1, 1'b1, '1);

        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                settle();
                case (p)
                    1:
                    begin
                        write_reg(bamde_pkg::CFG_FILTER_ADDRESS, '1);
                        write_reg(bamde_pkg::CFG_WANTED_TYPE, 48'h00);
                        write_reg(bamde_pkg::CFG_SKIP_COUNT, 48'd0);
                    end
                    2:
                    begin
                        write_reg(bamde_pkg::CFG_FILTER_ADDRESS, '0);
                        write_reg(bamde_pkg::CFG_WANTED_TYPE, 48'hFF);
                        write_reg(bamde_pkg::CFG_SKIP_COUNT, 48'd254);
                    end
                    3:
                    begin
                        write_reg(bamde_pkg::CFG_FILTER_ADDRESS, rand_addr());
                        write_reg(bamde_pkg::CFG_WANTED_TYPE, 48'($urandom_range(0, 255)));
                        write_reg(bamde_pkg::CFG_SKIP_COUNT, 48'($urandom_range(0, 5)));
                    end
                    4:
                    begin
                        write_reg(bamde_pkg::CFG_FILTER_ADDRESS, rand_addr());
                        write_reg(bamde_pkg::CFG_WANTED_TYPE, 48'hFF);
                        write_reg(bamde_pkg::CFG_SKIP_COUNT, 48'd2);
                    end
                    default:
                    begin
                        write_reg(bamde_pkg::CFG_FILTER_ADDRESS, rand_addr());
                        write_reg(bamde_pkg::CFG_WANTED_TYPE, 48'($urandom_range(0, 255)));
                        write_reg(bamde_pkg::CFG_SKIP_COUNT, 48'($urandom_range(0, 8)));
                    end
                endcase
            end
            settings_run++;
            run_random(p == 2 ? 150 : 330);
        end

        drain();
        repeat (SETTLE_CYCS) @(posedge clk);

        $display("sent %0d report bytes under %0d register settings, %0d reports cut short",
                 sent_items, settings_run, cut_reports);
        $display("checked %0d extracted bytes, %0d mismatches",
                 tracker.checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.expected_msgs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
